/* hdl/tpn_pkg.sv */
package tpn_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_TYPE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 8'd1;

  localparam logic [2:0] NT_OFF          = 3'd0;
  localparam logic [2:0] NT_WHITE_MONO   = 3'd1;
  localparam logic [2:0] NT_PINK_MONO    = 3'd2;
  localparam logic [2:0] NT_WHITE_STEREO = 3'd3;
  localparam logic [2:0] NT_PINK_STEREO  = 3'd4;

  localparam logic [1:0] KIND_OFF   = 2'd0;
  localparam logic [1:0] KIND_WHITE = 2'd1;
  localparam logic [1:0] KIND_PINK  = 2'd2;

  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  localparam int POLES = 7;

  // Q0.23 filter coefficients
  localparam logic signed [23:0] POLE_DECAY [6] = '{
    24'sd8379045, 24'sd8332572, 24'sd8128561, 24'sd7268729, 24'sd4613734, -24'sd6388764
  };
  localparam logic signed [23:0] POLE_GAIN [POLES] = '{
    24'sd465718, 24'sd629782, 24'sd1290604, 24'sd2604542, 24'sd4470727, -24'sd141751,
    24'sd972458
  };
  localparam logic signed [23:0] DIRECT_GAIN = 24'sd4497972;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic       stereo;
  } tpn_ctrl_t;

  typedef struct packed {
    logic signed [23:0] right;
    logic signed [23:0] left;
  } tpn_res_t;

  function automatic logic signed [31:0] rnd_sat_q23(input logic signed [57:0] acc);
    logic signed [57:0] t;
    t = (acc + 58'sd4194304) >>> 23;
    if (t > 58'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (t < -58'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return t[31:0];
    end
  endfunction

  function automatic logic signed [23:0] rnd_sat_q15(input logic signed [34:0] s);
    logic signed [34:0] t;
    t = (s + 35'sd128) >>> 8;
    if (t > 35'sd8388607) begin
      return 24'sh7fffff;
    end else if (t < -35'sd8388608) begin
      return 24'sh800000;
    end else begin
      return t[23:0];
    end
  endfunction

endpackage

/* hdl/tpn_white_table.sv */
module tpn_white_table #(
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH),
  parameter int LW    = ((AW + 1) > 17) ? (AW + 1) : 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [LW-1:0]       eff_len,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [15:0]  wr_data,
  output logic signed [15:0]  rd_data
);

  logic [15:0]        mem [DEPTH];
  logic [AW-1:0]      pos_r;
  logic [AW-1:0]      pos_nxt;
  logic [LW-1:0]      pos_inc;
  logic signed [15:0] rd_r;

  always_comb begin
    pos_inc = LW'(pos_r) + LW'(1);
    if (pos_inc >= eff_len) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_inc[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (adv) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (adv) begin
      rd_r <= mem[pos_nxt];
    end
  end

  assign rd_data = rd_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (LW'(pos_r) < eff_len || pos_r == '0))
    else $error("read position left the active table");

endmodule

/* hdl/tpn_pink_filter.sv */
module tpn_pink_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic signed [15:0] w,
  output logic signed [23:0] pink
);

  logic signed [23:0] w23;
  logic signed [47:0] gw_nxt [6];
  logic signed [47:0] gw_r   [6];
  logic signed [31:0] b6t_r;
  logic signed [31:0] dir_r;
  logic               en_a_r;
  logic signed [55:0] prod [6];
  logic signed [31:0] pole_nxt [6];
  logic signed [31:0] pole_r [tpn_pkg::POLES];
  logic signed [31:0] dir_b_r;
  logic signed [33:0] part0_r;
  logic signed [33:0] part1_r;
  logic signed [47:0] b6_prod;
  logic signed [47:0] dir_prod;

  assign w23 = $signed({w, 8'h00});

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      gw_nxt[k] = tpn_pkg::POLE_GAIN[k] * w23;
    end
    b6_prod  = tpn_pkg::POLE_GAIN[6] * w23;
    dir_prod = tpn_pkg::DIRECT_GAIN * w23;
  end

  // gain products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      gw_r[k] <= gw_nxt[k];
    end
    b6t_r <= tpn_pkg::rnd_sat_q23(58'(b6_prod));
    dir_r <= tpn_pkg::rnd_sat_q23(58'(dir_prod));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_a_r <= 1'b0;
    end else begin
      en_a_r <= en;
    end
  end

  // pole recursion
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      prod[k]     = tpn_pkg::POLE_DECAY[k] * pole_r[k];
      pole_nxt[k] = tpn_pkg::rnd_sat_q23(58'(prod[k]) + 58'(gw_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < tpn_pkg::POLES; k++) begin
        pole_r[k] <= '0;
      end
    end else if (en_a_r) begin
      for (int k = 0; k < 6; k++) begin
        pole_r[k] <= pole_nxt[k];
      end
      pole_r[6] <= b6t_r;
    end
  end

  always_ff @(posedge clk) begin
    dir_b_r <= dir_r;
    part0_r <= 34'(pole_r[0]) + 34'(pole_r[1]) + 34'(pole_r[2]) + 34'(pole_r[3]);
    part1_r <= 34'(pole_r[4]) + 34'(pole_r[5]) + 34'(pole_r[6]) + 34'(dir_b_r);
  end

  assign pink = tpn_pkg::rnd_sat_q15(35'(part0_r) + 35'(part1_r));

endmodule

/* hdl/tpn_out_fifo.sv */
module tpn_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tpn_pkg::tpn_res_t  push_data,
  input  logic               pop,
  output logic               valid,
  output tpn_pkg::tpn_res_t  data
);

  tpn_pkg::tpn_res_t               buf_r [tpn_pkg::OFIFO_DEPTH];
  logic [tpn_pkg::OFIFO_AW-1:0]    wr_ptr_r;
  logic [tpn_pkg::OFIFO_AW-1:0]    rd_ptr_r;
  logic [tpn_pkg::OFIFO_CW-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign valid = (count_r != '0);
  assign data  = buf_r[rd_ptr_r];

  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != tpn_pkg::OFIFO_CW'(tpn_pkg::OFIFO_DEPTH) || pop))
    else $error("result queue overflow");

endmodule

/* hdl/table_pink_noise_generator_core.sv */
// Two-channel noise source: per-channel looping tables of Q0.15 white samples feeding an
// optional seven-pole pink filter. Load words (tuser mode 0) write one table entry and give
// no result; tick words (mode 1) give one result word of left and right Q8.15 samples.
// One word is accepted every cycle while in_tready is high. An accepted tick's result goes
// through the table read on the accepting edge, then gain products, pole update and
// partial sums, with the final round and saturate on the way into the output queue. The
// pole recursion of each channel is one multiply-add per pole for the first six poles, and
// each table has one write and one read port. The output queue holds eight results;
// in_tready drops while eight tick results are in flight or waiting.
module table_pink_noise_generator_core #(
  parameter int TABLE_DEPTH = 65536,
  parameter int CHANNELS    = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // entry_index[15:0], entry_value[31:16]
  input  logic [1:0]                      in_tuser,   // mode[0], channel[1]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,  // left_sample[23:0], right_sample[47:24]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpn_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = ((AW + 1) > 17) ? (AW + 1) : 17;
  localparam int IW = ((AW + 1) > 16) ? (AW + 1) : 16;
  localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);
  localparam logic [LW-1:0] LEN_RST = (TABLE_DEPTH < 65536) ? LW'(TABLE_DEPTH) : LW'(65536);
  localparam logic [tpn_pkg::OFIFO_CW-1:0] CREDITS =
    tpn_pkg::OFIFO_CW'(tpn_pkg::OFIFO_DEPTH);

  logic [2:0]                   noise_type_r;
  logic [LW-1:0]                eff_len_r;
  logic [LW-1:0]                len_ext;
  logic [LW-1:0]                eff_len_nxt;
  logic                         in_acc;
  logic                         tick;
  logic                         is_white;
  logic                         is_pink;
  logic                         stereo;
  logic [IW-1:0]                idx_ext;
  logic                         idx_ok;
  tpn_pkg::tpn_ctrl_t           ctrl_nxt;
  tpn_pkg::tpn_ctrl_t           ctrl_r [4];
  logic signed [15:0]           w_rd   [CHANNELS];
  logic signed [15:0]           wd_r   [CHANNELS][3];
  logic signed [23:0]           pink_s [CHANNELS];
  logic signed [23:0]           chan_s [CHANNELS];
  tpn_pkg::tpn_res_t            res;
  tpn_pkg::tpn_res_t            fifo_data;
  logic                         out_acc;
  logic [tpn_pkg::OFIFO_CW-1:0] credit_r;

  assign cfg_ready = 1'b1;
  assign in_tready = (credit_r != CREDITS);
  assign in_acc    = in_tvalid && in_tready;
  assign tick      = in_tuser[0];
  assign out_acc   = out_tvalid && out_tready;

  always_comb begin
    len_ext = LW'(cfg_data);
    if (len_ext > DEPTH_L) begin
      eff_len_nxt = DEPTH_L;
    end else if (len_ext == '0) begin
      eff_len_nxt = LW'(1);
    end else begin
      eff_len_nxt = len_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_type_r <= tpn_pkg::NT_OFF;
      eff_len_r    <= LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpn_pkg::CFG_NOISE_TYPE:   noise_type_r <= cfg_data[2:0];
        tpn_pkg::CFG_TABLE_LENGTH: eff_len_r    <= eff_len_nxt;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_white = (noise_type_r == tpn_pkg::NT_WHITE_MONO) ||
               (noise_type_r == tpn_pkg::NT_WHITE_STEREO);
    is_pink  = (noise_type_r == tpn_pkg::NT_PINK_MONO) ||
               (noise_type_r == tpn_pkg::NT_PINK_STEREO);
    stereo   = ((noise_type_r == tpn_pkg::NT_WHITE_STEREO) ||
                (noise_type_r == tpn_pkg::NT_PINK_STEREO)) && (CHANNELS > 1);
    ctrl_nxt.vld    = in_acc && tick;
    ctrl_nxt.kind   = is_pink ? tpn_pkg::KIND_PINK :
                      (is_white ? tpn_pkg::KIND_WHITE : tpn_pkg::KIND_OFF);
    ctrl_nxt.stereo = stereo;
    idx_ext = IW'(in_tdata[15:0]);
    idx_ok  = idx_ext < IW'(TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 4; s++) begin
        ctrl_r[s] <= '0;
      end
    end else begin
      ctrl_r[0] <= ctrl_nxt;
      for (int s = 1; s < 4; s++) begin
        ctrl_r[s] <= ctrl_r[s-1];
      end
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic adv;
    logic wr_en;
    logic pink_en;

    assign adv     = in_acc && tick && (is_white || is_pink) && (c == 0 || stereo);
    assign wr_en   = in_acc && !tick && idx_ok && (in_tuser[1] == 1'(c));
    assign pink_en = ctrl_r[0].vld && (ctrl_r[0].kind == tpn_pkg::KIND_PINK) &&
                     (c == 0 || ctrl_r[0].stereo);

    tpn_white_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW),
      .LW    (LW)
    ) u_table (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .eff_len (eff_len_r),
      .wr_en   (wr_en),
      .wr_addr (idx_ext[AW-1:0]),
      .wr_data (in_tdata[31:16]),
      .rd_data (w_rd[c])
    );

    tpn_pink_filter u_pink (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pink_en),
      .w     (w_rd[c]),
      .pink  (pink_s[c])
    );

    always_ff @(posedge clk) begin
      wd_r[c][0] <= w_rd[c];
      wd_r[c][1] <= wd_r[c][0];
      wd_r[c][2] <= wd_r[c][1];
    end

    always_comb begin
      case (ctrl_r[3].kind)
        tpn_pkg::KIND_WHITE: chan_s[c] = 24'(wd_r[c][2]);
        tpn_pkg::KIND_PINK:  chan_s[c] = pink_s[c];
        default:             chan_s[c] = '0;
      endcase
    end
  end

  assign res.left  = chan_s[0];
  assign res.right = ctrl_r[3].stereo ? chan_s[CHANNELS-1] : chan_s[0];

  tpn_out_fifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ctrl_r[3].vld),
    .push_data (res),
    .pop       (out_acc),
    .valid     (out_tvalid),
    .data      (fifo_data)
  );

  assign out_tdata = fifo_data;

  // count results owed: in flight plus queued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else if (ctrl_nxt.vld && !out_acc) begin
      credit_r <= credit_r + 1'b1;
    end else if (out_acc && !ctrl_nxt.vld) begin
      credit_r <= credit_r - 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0]) |=> ctrl_r[0].vld)
    else $error("accepted tick did not enter the pipeline");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser[0]) |=> !ctrl_r[0].vld)
    else $error("load word produced a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (credit_r != '0))
    else $error("result queued without an owed credit");

endmodule
